FILE: sv/keyed_nlfsr_differential_pair_check_assert.svh
// assertion macros for the differential pair check block
`ifndef KEYED_NLFSR_DIFFERENTIAL_PAIR_CHECK_ASSERT_SVH
`define KEYED_NLFSR_DIFFERENTIAL_PAIR_CHECK_ASSERT_SVH

// same-cycle implication, off while in reset
`define KN_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define KN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, checked through reset as well
`define KN_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/knlfsr_pkg.sv
`default_nettype none

package knlfsr_pkg;

  localparam int WORD_W     = 32;
  localparam int STATE_W    = 128;
  localparam int HALF_W     = 64;
  localparam int NUM_WORDS  = STATE_W / WORD_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int WR_W       = 6;

  localparam int MAX_WORD_ROUNDS_DEF = 32;
  // rounds done back to back inside one pipeline stage
  localparam int ROUNDS_PER_STAGE    = 4;

  // feedback taps, as bit offsets into the 128-bit state
  localparam int TAP_A = 47;
  localparam int TAP_B = 70;
  localparam int TAP_C = 85;
  localparam int TAP_D = 91;

  localparam logic [WR_W-1:0] WORD_ROUNDS_RST = 6'd8;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IN_DIFF_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IN_DIFF_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_DIFF_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_DIFF_HIGH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_ROUNDS   = 3'd6;

  typedef logic [STATE_W-1:0] state_t;
  typedef logic [WORD_W-1:0]  word_t;

  // one 32-step round: new word enters at the top, state shifts down one word
  function automatic state_t round_f(state_t s, word_t k);
    word_t fb;
    fb = s[WORD_W-1:0] ^ s[TAP_A +: WORD_W]
       ^ ~(s[TAP_B +: WORD_W] & s[TAP_C +: WORD_W])
       ^ s[TAP_D +: WORD_W] ^ k;
    return {fb, s[STATE_W-1:WORD_W]};
  endfunction

endpackage

`default_nettype wire

FILE: sv/knlfsr_in_if.sv
`default_nettype none

interface knlfsr_in_if;
  import knlfsr_pkg::*;

  logic              valid;
  logic              ready;
  logic [HALF_W-1:0] cand_low;
  logic [HALF_W-1:0] cand_high;

  modport source (output valid, output cand_low, output cand_high, input ready);
  modport sink   (input valid, input cand_low, input cand_high, output ready);
endinterface

`default_nettype wire

FILE: sv/knlfsr_out_if.sv
`default_nettype none

interface knlfsr_out_if;
  import knlfsr_pkg::*;

  logic              valid;
  logic              ready;
  logic              conforms;
  logic [HALF_W-1:0] final_a_low;
  logic [HALF_W-1:0] final_a_high;
  logic [HALF_W-1:0] final_b_low;
  logic [HALF_W-1:0] final_b_high;

  modport source (output valid, output conforms, output final_a_low, output final_a_high,
                  output final_b_low, output final_b_high, input ready);
  modport sink   (input valid, input conforms, input final_a_low, input final_a_high,
                  input final_b_low, input final_b_high, output ready);
endinterface

`default_nettype wire

FILE: sv/keyed_nlfsr_differential_pair_check.sv
// path: input register, round stages, result register; each round stage does up to
// four rounds on both states; throughput: one candidate per cycle unless out_ch stalls
// the configured round count only gates rounds, so latency does not depend on it
// reset (synchronous, rst_n low) empties the pipeline and returns the configuration
// registers to zero, with word_rounds at 8; no clearing pass is needed
`default_nettype none

module keyed_nlfsr_differential_pair_check #(
  parameter int MAX_WORD_ROUNDS = knlfsr_pkg::MAX_WORD_ROUNDS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [knlfsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [knlfsr_pkg::CFG_DATA_W-1:0] cfg_data,
  knlfsr_in_if.sink                              in_ch,
  knlfsr_out_if.source                           out_ch
);
  import knlfsr_pkg::*;

  localparam int NUM_STAGES = (MAX_WORD_ROUNDS + ROUNDS_PER_STAGE - 1) / ROUNDS_PER_STAGE;

  logic [HALF_W-1:0] key_low_r, key_high_r;
  logic [HALF_W-1:0] in_diff_low_r, in_diff_high_r;
  logic [HALF_W-1:0] out_diff_low_r, out_diff_high_r;
  logic [WR_W-1:0]   word_rounds_r;

  word_t  key_w [NUM_WORDS];
  state_t in_diff;
  state_t out_diff;

  state_t              st_a_r [0:NUM_STAGES];
  state_t              st_b_r [0:NUM_STAGES];
  logic [NUM_STAGES:0] vld_r;
  state_t              nxt_a [1:NUM_STAGES];
  state_t              nxt_b [1:NUM_STAGES];
  logic [NUM_STAGES+1:0] rdy;

  logic   out_vld_r;
  logic   conforms_r;
  state_t fin_a_r;
  state_t fin_b_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r       <= '0;
      key_high_r      <= '0;
      in_diff_low_r   <= '0;
      in_diff_high_r  <= '0;
      out_diff_low_r  <= '0;
      out_diff_high_r <= '0;
      word_rounds_r   <= WORD_ROUNDS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_LOW:       key_low_r       <= cfg_data;
        REG_KEY_HIGH:      key_high_r      <= cfg_data;
        REG_IN_DIFF_LOW:   in_diff_low_r   <= cfg_data;
        REG_IN_DIFF_HIGH:  in_diff_high_r  <= cfg_data;
        REG_OUT_DIFF_LOW:  out_diff_low_r  <= cfg_data;
        REG_OUT_DIFF_HIGH: out_diff_high_r <= cfg_data;
        REG_WORD_ROUNDS:   word_rounds_r   <= cfg_data[WR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    key_w[0] = key_low_r[WORD_W-1:0];
    key_w[1] = key_low_r[HALF_W-1:WORD_W];
    key_w[2] = key_high_r[WORD_W-1:0];
    key_w[3] = key_high_r[HALF_W-1:WORD_W];
  end

  assign in_diff  = {in_diff_high_r, in_diff_low_r};
  assign out_diff = {out_diff_high_r, out_diff_low_r};

  // per-stage ready: a stage can load when empty or when its content moves on
  always_comb begin
    rdy[NUM_STAGES+1] = !out_vld_r || out_ch.ready;
    for (int j = NUM_STAGES; j >= 0; j--) begin
      rdy[j] = !vld_r[j] || rdy[j+1];
    end
  end

  assign in_ch.ready = rdy[0];

  // stage 0: input register, pair partner formed on entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld_r[0] <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      st_a_r[0] <= {in_ch.cand_high, in_ch.cand_low};
      st_b_r[0] <= {in_ch.cand_high, in_ch.cand_low} ^ in_diff;
    end
  end

  // round stages
  for (genvar j = 1; j <= NUM_STAGES; j++) begin : g_stage
    always_comb begin
      state_t sa;
      state_t sb;
      int     r;
      sa = st_a_r[j-1];
      sb = st_b_r[j-1];
      for (int q = 0; q < ROUNDS_PER_STAGE; q++) begin
        r = (j - 1) * ROUNDS_PER_STAGE + q;
        // rounds past the maximum never run, which saturates the count
        if (r < MAX_WORD_ROUNDS && r < int'(word_rounds_r)) begin
          sa = round_f(sa, key_w[2'(r)]);
          sb = round_f(sb, key_w[2'(r)]);
        end
      end
      nxt_a[j] = sa;
      nxt_b[j] = sb;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (rdy[j]) begin
        vld_r[j] <= vld_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[j]) begin
        st_a_r[j] <= nxt_a[j];
        st_b_r[j] <= nxt_b[j];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (rdy[NUM_STAGES+1]) begin
      out_vld_r <= vld_r[NUM_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NUM_STAGES+1]) begin
      fin_a_r    <= st_a_r[NUM_STAGES];
      fin_b_r    <= st_b_r[NUM_STAGES];
      conforms_r <= ((st_a_r[NUM_STAGES] ^ st_b_r[NUM_STAGES]) == out_diff);
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.conforms     = conforms_r;
  assign out_ch.final_a_low  = fin_a_r[HALF_W-1:0];
  assign out_ch.final_a_high = fin_a_r[STATE_W-1:HALF_W];
  assign out_ch.final_b_low  = fin_b_r[HALF_W-1:0];
  assign out_ch.final_b_high = fin_b_r[STATE_W-1:HALF_W];

endmodule

`default_nettype wire

FILE: sv/knlfsr_checker.sv
`default_nettype none

`include "keyed_nlfsr_differential_pair_check_assert.svh"

module knlfsr_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic                      out_conforms,
  input wire logic [knlfsr_pkg::HALF_W-1:0] out_final_a_low,
  input wire logic [knlfsr_pkg::HALF_W-1:0] out_final_a_high,
  input wire logic [knlfsr_pkg::HALF_W-1:0] out_final_b_low,
  input wire logic [knlfsr_pkg::HALF_W-1:0] out_final_b_high
);
  import knlfsr_pkg::*;

  // reset empties the pipeline, so no result can show the cycle after
  `KN_ASSERT_NEXT_ALWAYS(a_rst_empty, !rst_n, !out_valid, "result valid right after reset")

  // a free result slot makes the whole pipeline ready
  `KN_ASSERT_IMPL(a_ready_flow, !out_valid || out_ready, in_ready,
                  "input stalled while result side is free")

  `KN_ASSERT_NEXT(a_valid_hold, out_valid && !out_ready, out_valid,
                  "result dropped before transaction")

  `KN_ASSERT_NEXT(a_data_hold, out_valid && !out_ready,
                  $stable({out_conforms, out_final_a_low, out_final_a_high,
                           out_final_b_low, out_final_b_high}),
                  "stalled result changed")

endmodule

bind keyed_nlfsr_differential_pair_check knlfsr_checker u_knlfsr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_conforms     (out_ch.conforms),
  .out_final_a_low  (out_ch.final_a_low),
  .out_final_a_high (out_ch.final_a_high),
  .out_final_b_low  (out_ch.final_b_low),
  .out_final_b_high (out_ch.final_b_high)
);

`default_nettype wire

FILE: tb/keyed_nlfsr_differential_pair_check_tb.sv
module keyed_nlfsr_differential_pair_check_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import knlfsr_pkg::*;

  localparam int MAX_ROUNDS   = MAX_WORD_ROUNDS_DEF;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLDOFF_LEN  = 300;
  // index 7 is not mapped to any register
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef struct packed {
    logic        conforms;
    logic [63:0] a_low;
    logic [63:0] a_high;
    logic [63:0] b_low;
    logic [63:0] b_high;
  } pair_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  knlfsr_in_if  in_ch ();
  knlfsr_out_if out_ch ();

  keyed_nlfsr_differential_pair_check dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // mirror of the configuration registers
  logic [127:0]    key_words;
  logic [127:0]    in_diff;
  logic [127:0]    out_diff;
  logic [WR_W-1:0] word_rounds_reg;

  pair_result_t pending_pairs[$];
  int           error_count;
  int           cycle_count;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           holdoff_left;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("keyed_nlfsr_differential_pair_check verification failed");
      $finish;
    end
  end

  // result side: long hold-off when requested, otherwise random stalls
  always @(posedge clk) begin
    if (holdoff_left > 0) begin
      out_ch.ready <= 1'b0;
      holdoff_left--;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [127:0] nlfsr_permute(logic [127:0] st, int nrounds);
    logic [31:0] w0, w1, w2, w3, t47, t70, t85, t91, fb;
    for (int r = 0; r < nrounds; r++) begin
      w0  = st[31:0];
      w1  = st[63:32];
      w2  = st[95:64];
      w3  = st[127:96];
      t47 = (w1 >> 15) | (w2 << 17);
      t70 = (w2 >> 6) | (w3 << 26);
      t85 = (w2 >> 21) | (w3 << 11);
      t91 = (w2 >> 27) | (w3 << 5);
      fb  = w0 ^ t47 ^ ~(t70 & t85) ^ t91 ^ key_words[(r % 4) * 32 +: 32];
      st  = {fb, w3, w2, w1};
    end
    return st;
  endfunction

  function automatic pair_result_t pair_check_predict(logic [127:0] cand);
    pair_result_t res;
    logic [127:0] sa, sb;
    int nr;
    // round counts past the maximum saturate
    nr = (int'(word_rounds_reg) > MAX_ROUNDS) ? MAX_ROUNDS : int'(word_rounds_reg);
    sa = nlfsr_permute(cand, nr);
    sb = nlfsr_permute(cand ^ in_diff, nr);
    res.conforms = ((sa ^ sb) == out_diff);
    res.a_low    = sa[63:0];
    res.a_high   = sa[127:64];
    res.b_low    = sb[63:0];
    res.b_high   = sb[127:64];
    return res;
  endfunction

  function automatic logic [63:0] rand_reg64();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [127:0] rand_cand();
    return {rand_reg64(), rand_reg64()};
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_KEY_LOW:       key_words[63:0]   = data;
      REG_KEY_HIGH:      key_words[127:64] = data;
      REG_IN_DIFF_LOW:   in_diff[63:0]     = data;
      REG_IN_DIFF_HIGH:  in_diff[127:64]   = data;
      REG_OUT_DIFF_LOW:  out_diff[63:0]    = data;
      REG_OUT_DIFF_HIGH: out_diff[127:64]  = data;
      REG_WORD_ROUNDS:   word_rounds_reg   = data[WR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_pair(input logic [CFG_IDX_W-1:0] idx_low,
                            input logic [CFG_IDX_W-1:0] idx_high, input logic [127:0] value);
    write_reg(idx_low, value[63:0]);
    write_reg(idx_high, value[127:64]);
  endtask

  task automatic write_rounds(input logic [WR_W-1:0] rounds);
    // upper data bits are don't-care for this register
    write_reg(REG_WORD_ROUNDS, {$urandom, 26'($urandom_range(2**26 - 1)), rounds});
  endtask

  task automatic send_cand(input logic [127:0] cand);
    logic took;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cand_low  <= cand[63:0];
    in_ch.cand_high <= cand[127:64];
    do begin
      @(negedge clk);
      took = (in_ch.ready === 1'b1);
      @(posedge clk);
    end while (!took);
    pending_pairs.push_back(pair_check_predict(cand));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // values stay stable from negedge to the accepting posedge
  always @(negedge clk) begin : check_results
    pair_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_pairs.size() == 0) begin
        $error("result transaction with no expected result pending");
        error_count++;
      end else begin
        want = pending_pairs.pop_front();
        if (out_ch.conforms !== want.conforms) begin
          $error("conforms: expected %0b, got %0b", want.conforms, out_ch.conforms);
          error_count++;
        end
        if (out_ch.final_a_low !== want.a_low) begin
          $error("final_a_low: expected %h, got %h", want.a_low, out_ch.final_a_low);
          error_count++;
        end
        if (out_ch.final_a_high !== want.a_high) begin
          $error("final_a_high: expected %h, got %h", want.a_high, out_ch.final_a_high);
          error_count++;
        end
        if (out_ch.final_b_low !== want.b_low) begin
          $error("final_b_low: expected %h, got %h", want.b_low, out_ch.final_b_low);
          error_count++;
        end
        if (out_ch.final_b_high !== want.b_high) begin
          $error("final_b_high: expected %h, got %h", want.b_high, out_ch.final_b_high);
          error_count++;
        end
      end
    end
  end

  task automatic test_reset_defaults();
    // zero key and differences, eight rounds: every pair conforms
    send_cand('0);
    send_cand('1);
    wait_drained();
  endtask

  task automatic test_field_extremes();
    write_pair(REG_KEY_LOW, REG_KEY_HIGH, '1);
    write_pair(REG_IN_DIFF_LOW, REG_IN_DIFF_HIGH, '1);
    write_pair(REG_OUT_DIFF_LOW, REG_OUT_DIFF_HIGH, '0);
    send_cand('0);
    send_cand('1);
    send_cand({1'b1, 127'b0});
    send_cand(128'd1);
    send_cand({4{32'haaaa_5555}});
    wait_drained();
  endtask

  task automatic test_zero_rounds();
    logic [127:0] cand, delta;
    cand  = rand_cand();
    delta = {$urandom, $urandom, $urandom, $urandom};
    write_rounds('0);
    write_pair(REG_IN_DIFF_LOW, REG_IN_DIFF_HIGH, delta);
    // no rounds: the difference comes out as it went in
    write_pair(REG_OUT_DIFF_LOW, REG_OUT_DIFF_HIGH, delta);
    send_cand(cand);
    wait_drained();
    write_reg(REG_OUT_DIFF_LOW, delta[63:0] ^ 64'd1);
    send_cand(cand);
    wait_drained();
  endtask

  task automatic test_round_counts();
    logic [127:0] cand;
    cand = rand_cand();
    write_pair(REG_KEY_LOW, REG_KEY_HIGH, {$urandom, $urandom, $urandom, $urandom});
    write_rounds(6'd1);
    send_cand(cand);
    wait_drained();
    write_rounds(6'(MAX_ROUNDS));
    send_cand(cand);
    wait_drained();
    // above the maximum: saturates
    write_rounds(6'(MAX_ROUNDS + 1));
    send_cand(cand);
    wait_drained();
    write_rounds('1);
    send_cand(cand);
    wait_drained();
  endtask

  task automatic test_unmapped_index();
    write_rounds(6'd8);
    write_reg(REG_UNMAPPED, '1);
    send_cand(rand_cand());
    wait_drained();
  endtask

  task automatic test_conforming_pair();
    logic [127:0] cand;
    pair_result_t res;
    cand = rand_cand();
    write_pair(REG_IN_DIFF_LOW, REG_IN_DIFF_HIGH, {$urandom, $urandom, $urandom, $urandom});
    res = pair_check_predict(cand);
    write_pair(REG_OUT_DIFF_LOW, REG_OUT_DIFF_HIGH,
               {res.a_high ^ res.b_high, res.a_low ^ res.b_low});
    send_cand(cand);
    send_cand(~cand);
    wait_drained();
  endtask

  task automatic randomize_config();
    logic [WR_W-1:0] rounds;
    write_pair(REG_KEY_LOW, REG_KEY_HIGH, {rand_reg64(), rand_reg64()});
    write_pair(REG_IN_DIFF_LOW, REG_IN_DIFF_HIGH, {rand_reg64(), rand_reg64()});
    write_pair(REG_OUT_DIFF_LOW, REG_OUT_DIFF_HIGH, {rand_reg64(), rand_reg64()});
    case ($urandom_range(5))
      0:       rounds = '0;
      1:       rounds = 6'(MAX_ROUNDS);
      2:       rounds = 6'($urandom_range(63, MAX_ROUNDS + 1));
      default: rounds = 6'($urandom_range(MAX_ROUNDS, 1));
    endcase
    write_rounds(rounds);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
    logic [127:0] anchor;
    pair_result_t res;
    randomize_config();
    anchor = rand_cand();
    // target difference taken from one candidate so that some pairs conform
    if ($urandom_range(1)) begin
      res = pair_check_predict(anchor);
      write_pair(REG_OUT_DIFF_LOW, REG_OUT_DIFF_HIGH,
                 {res.a_high ^ res.b_high, res.a_low ^ res.b_low});
    end
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(7) == 0) send_cand(anchor);
      else send_cand(rand_cand());
    end
    wait_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_random_phases();
    run_phase(0, 0, 130);
    run_phase(62, 0, 130);
    run_phase(0, 62, 130);
    run_phase(11, 11, 130);
  endtask

  task automatic test_backpressure();
    randomize_config();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    holdoff_left   = HOLDOFF_LEN;
    // pipeline fills up during the hold-off and input must stall
    for (int i = 0; i < 40; i++) send_cand(rand_cand());
    wait_drained();
    for (int i = 0; i < 10; i++) send_cand(rand_cand());
    wait_drained();
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.cand_low  = '0;
    in_ch.cand_high = '0;
    out_ch.ready    = 1'b0;
    key_words       = '0;
    in_diff         = '0;
    out_diff        = '0;
    word_rounds_reg = WORD_ROUNDS_RST;
    error_count     = 0;
    cycle_count     = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    holdoff_left    = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_field_extremes();
    test_zero_rounds();
    test_round_counts();
    test_unmapped_index();
    test_conforming_pair();
    test_random_phases();
    test_backpressure();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_pairs.size() == 0) begin
      $display("keyed_nlfsr_differential_pair_check verification clean");
    end else begin
      $display("keyed_nlfsr_differential_pair_check verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/knlfsr_pkg.sv
sv/knlfsr_in_if.sv
sv/knlfsr_out_if.sv
sv/keyed_nlfsr_differential_pair_check.sv
sv/knlfsr_checker.sv
tb/keyed_nlfsr_differential_pair_check_tb.sv
